@@ rtl/clipped_alpha_blend_blitter_macros.svh @@
// Assertion macros for the clipped alpha blend blitter.
// Included by the top level; needs no other file.
`ifndef CLIPPED_ALPHA_BLEND_BLITTER_MACROS_SVH
`define CLIPPED_ALPHA_BLEND_BLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define CABB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blitter check failed");
`define CABB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blitter check failed");
`else
`define CABB_ASSERT_IMP(label, clk, rst, ante, cons)
`define CABB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cabb_pkg.sv @@
// Types, constants and the channel blend function of the blitter.
// Depends on nothing; used by the interfaces and the top level.
`timescale 1ns / 1ps
package cabb_pkg;

  localparam int BYTES_PER_PIXEL = 4;
  localparam int MAX_DIMENSION   = 4096;

  localparam int DIM_W   = 13;
  localparam int PITCH_W = 15;
  localparam int POS_W   = 14;
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 3;
  localparam int PIX_W   = 32;
  localparam int RGB_W   = 24;
  localparam int ADDR_W  = 26;
  localparam int SIDX_W  = 24;

  typedef enum logic [IDX_W-1:0] {
    REG_DEST_WIDTH    = 3'd0,
    REG_DEST_HEIGHT   = 3'd1,
    REG_PITCH_BYTES   = 3'd2,
    REG_BITMAP_WIDTH  = 3'd3,
    REG_BITMAP_HEIGHT = 3'd4,
    REG_PLACE_X       = 3'd5,
    REG_PLACE_Y       = 3'd6
  } reg_index_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (32'(v) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : v;
  endfunction

  // Rounded blend divided by 255 through the usual reciprocal form, exact
  // for every sum that the channel can produce.
  function automatic logic [7:0] blend_chan(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a);
    logic [7:0]  na;
    logic [16:0] acc;
    logic [16:0] q;
    na  = 8'd255 - a;
    acc = 17'(na) * 17'(d) + 17'(a) * 17'(s) + 17'd127;
    q   = acc + 17'(acc[16:8]) + 17'd1;
    return q[15:8];
  endfunction

endpackage

@@ rtl/cabb_ifs.sv @@
// Valid/ready channel interfaces for the pixel words in and the results out.
// Depends on cabb_pkg for field widths.
`timescale 1ns / 1ps
interface cabb_in_if
  import cabb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_pixel;
  logic [PIX_W-1:0] dst_pixel;

  modport source (output valid, output src_pixel, output dst_pixel, input ready);
  modport sink (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface cabb_out_if
  import cabb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RGB_W-1:0]  blended_pixel;
  logic [ADDR_W-1:0] dest_address;
  logic [SIDX_W-1:0] source_index;
  logic              last_pixel;

  modport source (output valid, output blended_pixel, output dest_address,
                  output source_index, output last_pixel, input ready);
  modport sink (input valid, input blended_pixel, input dest_address,
                input source_index, input last_pixel, output ready);
endinterface

@@ rtl/clipped_alpha_blend_blitter.sv @@
// Clipped alpha blend blitter: one pixel word in, one blended word out per cycle
// while result.ready holds; words accepted while the clipped rectangle is empty
// give no result. Each word passes an input register holding pixels and
// coordinates, then the result register fed by the blend and address multipliers;
// the counters of the clipped walk are the only loop. Synchronous reset loads the
// register defaults, clears the walk counters and empties both stages.
`timescale 1ns / 1ps
`include "clipped_alpha_blend_blitter_macros.svh"
module clipped_alpha_blend_blitter
  import cabb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             write_enable,
  input  logic [IDX_W-1:0] register_index,
  input  logic [CFG_W-1:0] write_data,
  cabb_in_if.sink          feed,
  cabb_out_if.source       result
);

  logic [DIM_W-1:0]        dest_width, dest_height, bitmap_width, bitmap_height;
  logic [PITCH_W-1:0]      pitch_bytes;
  logic signed [POS_W-1:0] place_x, place_y;
  logic [DIM_W-1:0]        column_count, row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width    <= DIM_W'(1024);
      dest_height   <= DIM_W'(768);
      pitch_bytes   <= PITCH_W'(4096);
      bitmap_width  <= DIM_W'(64);
      bitmap_height <= DIM_W'(64);
      place_x       <= '0;
      place_y       <= '0;
    end else if (write_enable) begin
      unique case (register_index)
        REG_DEST_WIDTH:    dest_width    <= write_data[DIM_W-1:0];
        REG_DEST_HEIGHT:   dest_height   <= write_data[DIM_W-1:0];
        REG_PITCH_BYTES:   pitch_bytes   <= write_data[PITCH_W-1:0];
        REG_BITMAP_WIDTH:  bitmap_width  <= write_data[DIM_W-1:0];
        REG_BITMAP_HEIGHT: bitmap_height <= write_data[DIM_W-1:0];
        REG_PLACE_X:       place_x       <= write_data[POS_W-1:0];
        REG_PLACE_Y:       place_y       <= write_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clipped rectangle, fixed between configuration writes.
  logic [DIM_W-1:0]  dw, dh, bw, bh;
  logic signed [15:0] px, py, dw_s, dh_s, bw_s, bh_s;
  logic signed [15:0] min_x, min_y, max_x, max_y, off_x, off_y, ext_x, ext_y;
  logic signed [15:0] cols_s, rows_s;
  logic [DIM_W-1:0]  cols_m1, rows_m1;
  logic              empty;

  always_comb begin
    dw    = sat_dim(dest_width);
    dh    = sat_dim(dest_height);
    bw    = sat_dim(bitmap_width);
    bh    = sat_dim(bitmap_height);
    px    = {{2{place_x[POS_W-1]}}, place_x};
    py    = {{2{place_y[POS_W-1]}}, place_y};
    dw_s  = signed'({3'b000, dw});
    dh_s  = signed'({3'b000, dh});
    bw_s  = signed'({3'b000, bw});
    bh_s  = signed'({3'b000, bh});
    ext_x = px + bw_s;
    ext_y = py + bh_s;
    min_x = px[15] ? 16'sd0 : px;
    min_y = py[15] ? 16'sd0 : py;
    off_x = px[15] ? -px : 16'sd0;
    off_y = py[15] ? -py : 16'sd0;
    max_x = (ext_x > dw_s) ? dw_s : ext_x;
    max_y = (ext_y > dh_s) ? dh_s : ext_y;
    cols_s  = max_x - min_x;
    rows_s  = max_y - min_y;
    empty   = (cols_s <= 16'sd0) || (rows_s <= 16'sd0);
    cols_m1 = cols_s[DIM_W-1:0] - DIM_W'(1);
    rows_m1 = rows_s[DIM_W-1:0] - DIM_W'(1);
  end

  logic             s1_valid;
  logic [PIX_W-1:0] s1_src, s1_dst;
  logic [DIM_W-1:0] s1_x, s1_y, s1_row, s1_col;
  logic             s1_last;
  logic             out_valid;
  logic             out_load, accept, take;
  logic             col_end, row_end, item_last;

  assign out_load  = !out_valid || result.ready;
  assign feed.ready = !s1_valid || out_load;
  assign accept    = feed.valid && feed.ready;
  assign take      = accept && !empty;
  assign col_end   = column_count == cols_m1;
  assign row_end   = row_count == rows_m1;
  assign item_last = col_end && row_end;

  always_ff @(posedge clk) begin
    if (rst || write_enable) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + DIM_W'(1);
      end else begin
        column_count <= column_count + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= take;
    end
    if (accept) begin
      s1_src  <= feed.src_pixel;
      s1_dst  <= feed.dst_pixel;
      s1_x    <= min_x[DIM_W-1:0] + column_count;
      s1_y    <= min_y[DIM_W-1:0] + row_count;
      s1_row  <= bh - DIM_W'(1) - off_y[DIM_W-1:0] - row_count;
      s1_col  <= off_x[DIM_W-1:0] + column_count;
      s1_last <= item_last;
    end
  end

  logic [27:0] row_addr;
  logic [25:0] row_base;

  assign row_addr = 28'(s1_y) * 28'(pitch_bytes);
  assign row_base = 26'(s1_row) * 26'(bw);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && out_load) begin
      result.blended_pixel <= {blend_chan(s1_src[23:16], s1_dst[23:16], s1_src[31:24]),
                               blend_chan(s1_src[15:8], s1_dst[15:8], s1_src[31:24]),
                               blend_chan(s1_src[7:0], s1_dst[7:0], s1_src[31:24])};
      result.dest_address  <= ADDR_W'(28'(s1_x) * 28'(BYTES_PER_PIXEL) + row_addr);
      result.source_index  <= SIDX_W'(row_base + 26'(s1_col));
      result.last_pixel    <= s1_last;
    end
  end

  assign result.valid = out_valid;

  `CABB_ASSERT_NXT(a_wrap_after_last, clk, rst, take && item_last, column_count == '0 && row_count == '0)
  `CABB_ASSERT_NXT(a_cfg_restart, clk, rst, write_enable, column_count == '0 && row_count == '0)
  `CABB_ASSERT_IMP(a_count_in_rect, clk, rst, !empty, column_count <= cols_m1 && row_count <= rows_m1)
  `CABB_ASSERT_IMP(a_stall_blocks, clk, rst, out_valid && !result.ready && s1_valid, !feed.ready)

endmodule
